// ----- hw/rtl/kcl_pkg.sv -----
// Package for the keypad code lock: phase codes, status codes, request codes and defaults.
`timescale 1ns / 1ps

package kcl_pkg;

    localparam int CODE_W         = 32;
    localparam int CODE_BYTES     = CODE_W / 8;
    localparam int CODE_CHARS_DEF = 4;

    localparam logic [CODE_W-1:0] RESET_CODE = 32'h3131_3131;  // "1111"

    // Request codes
    localparam logic [1:0] REQ_ENTER  = 2'd0;
    localparam logic [1:0] REQ_CHANGE = 2'd1;
    localparam logic [1:0] REQ_CODE   = 2'd2;

    // Phase codes
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_ENTRY  = 3'd1;
    localparam logic [2:0] PH_OLD    = 3'd2;
    localparam logic [2:0] PH_NEW    = 3'd3;
    localparam logic [2:0] PH_REPEAT = 3'd4;

    // Status codes
    localparam logic [3:0] ST_CHOOSE    = 4'd0;
    localparam logic [3:0] ST_ASK_CODE  = 4'd1;
    localparam logic [3:0] ST_GRANTED   = 4'd2;
    localparam logic [3:0] ST_WRONG     = 4'd3;
    localparam logic [3:0] ST_ASK_NEW   = 4'd4;
    localparam logic [3:0] ST_ASK_REP   = 4'd5;
    localparam logic [3:0] ST_CHANGED   = 4'd6;
    localparam logic [3:0] ST_MISMATCH  = 4'd7;
    localparam logic [3:0] ST_CANCELLED = 4'd8;
    localparam logic [3:0] ST_IGNORED   = 4'd9;

    typedef logic [CODE_W-1:0] code_t;

endpackage

// ----- hw/rtl/keypad_code_lock.sv -----
// Keypad code lock controller: input register, phase logic and result register.
`timescale 1ns / 1ps
// An item in the input register moves to the result register when that stage is free.
// Throughput: one item per cycle unless m_ready stalls the result; two-stage pipeline.
// The phase, stored code and first new entry update in the same cycle the result registers.
// Reset (aresetn low, synchronous): both stages empty, phase idle, stored code "1111".
// The first new entry register has no reset; it is written before it is ever read.
module keypad_code_lock
    import kcl_pkg::*;
#(
    parameter int CODE_CHARS = CODE_CHARS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [31:0] s_code_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_status,
    output logic        m_access_granted
);

    // Only the first characters (top bytes) take part in a compare.
    localparam int CMP_BYTES = (CODE_CHARS >= CODE_BYTES) ? CODE_BYTES : CODE_CHARS;
    localparam code_t CMP_MASK = {CODE_W{1'b1}} << (8 * (CODE_BYTES - CMP_BYTES));

    // Input stage
    logic        in_valid_reg;
    logic [1:0]  in_req_reg;
    code_t       in_code_reg;

    // Result stage
    logic        out_valid_reg;
    logic [3:0]  out_status_reg;
    logic        out_granted_reg;

    // Lock state
    logic [2:0]  phase_reg, phase_next;
    code_t       stored_code_reg, stored_code_next;
    code_t       first_new_reg, first_new_next;

    logic [3:0]  status_next;
    logic        granted_next;
    logic        out_free;
    logic        fire;
    logic        match_stored;
    logic        match_first;

    // Result stage can take a new item when empty or being drained.
    assign out_free = !out_valid_reg || m_ready;
    assign fire     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    assign match_stored = ((in_code_reg ^ stored_code_reg) & CMP_MASK) == '0;
    assign match_first  = ((in_code_reg ^ first_new_reg) & CMP_MASK) == '0;

    // Phase and status update for the item in the input stage.
    always_comb begin
        phase_next       = phase_reg;
        stored_code_next = stored_code_reg;
        first_new_next   = first_new_reg;
        status_next      = ST_IGNORED;
        granted_next     = 1'b0;
        if (in_req_reg == REQ_ENTER || in_req_reg == REQ_CHANGE || in_req_reg == REQ_CODE) begin
            unique case (phase_reg)
                PH_IDLE: begin
                    if (in_req_reg == REQ_ENTER) begin
                        phase_next  = PH_ENTRY;
                        status_next = ST_ASK_CODE;
                    end else if (in_req_reg == REQ_CHANGE) begin
                        phase_next  = PH_OLD;
                        status_next = ST_ASK_CODE;
                    end else begin
                        status_next = ST_CHOOSE;
                    end
                end
                PH_ENTRY: begin
                    // Keys are ignored while waiting for the entry code.
                    if (in_req_reg == REQ_CODE) begin
                        status_next  = match_stored ? ST_GRANTED : ST_WRONG;
                        granted_next = match_stored;
                        phase_next   = PH_IDLE;
                    end
                end
                PH_OLD, PH_NEW, PH_REPEAT: begin
                    if (in_req_reg == REQ_CHANGE) begin
                        status_next = ST_CANCELLED;
                        phase_next  = PH_IDLE;
                    end else if (in_req_reg == REQ_CODE) begin
                        if (phase_reg == PH_OLD) begin
                            status_next = match_stored ? ST_ASK_NEW : ST_WRONG;
                            phase_next  = match_stored ? PH_NEW : PH_IDLE;
                        end else if (phase_reg == PH_NEW) begin
                            first_new_next = in_code_reg;
                            status_next    = ST_ASK_REP;
                            phase_next     = PH_REPEAT;
                        end else begin
                            if (match_first) begin
                                stored_code_next = in_code_reg;
                                status_next      = ST_CHANGED;
                            end else begin
                                status_next = ST_MISMATCH;
                            end
                            phase_next = PH_IDLE;
                        end
                    end
                end
                default: begin
                    // Unused phase codes fall back to idle.
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            phase_reg       <= PH_IDLE;
            stored_code_reg <= RESET_CODE;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire) begin
                phase_reg       <= phase_next;
                stored_code_reg <= stored_code_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_req_reg  <= s_req_type;
            in_code_reg <= s_code_word;
        end
        if (fire) begin
            out_status_reg  <= status_next;
            out_granted_reg <= granted_next;
            first_new_reg   <= first_new_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_status         = out_status_reg;
    assign m_access_granted = out_granted_reg;

    // Grant only comes with the granted status.
    a_grant_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_granted_reg) |-> (out_status_reg == ST_GRANTED))
        else $error("access granted without granted status");

    // Phase stays within the used codes.
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= PH_REPEAT)
        else $error("phase left the used range");

    // Enter key in idle moves to the entry prompt.
    a_enter_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && phase_reg == PH_IDLE && in_req_reg == REQ_ENTER) |=> (phase_reg == PH_ENTRY))
        else $error("enter key in idle did not ask for the code");

    // A reported change stores the typed code.
    a_code_stored: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && status_next == ST_CHANGED) |=> (stored_code_reg == $past(in_code_reg)))
        else $error("changed code not stored");

    // Stored code only moves on a reported change.
    a_code_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(fire && status_next == ST_CHANGED) |=> $stable(stored_code_reg))
        else $error("stored code moved without a change");

endmodule
